// ===== hw/rtl/bqd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqd_pkg
// shared types and constants of the direct-form-I biquad
// ----------------------------------------------------------------------------
package bqd_pkg;

	localparam int COEF_W    = 24;
	localparam int GAIN_W    = 24;
	localparam int COEF_FRAC = 21;
	localparam int GAIN_FRAC = 20;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FF_COEF0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FF_COEF1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FF_COEF2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FB_COEF1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FB_COEF2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 3'd5;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'd1048576;

	// product steps of the shared multiplier
	localparam logic [STEP_W-1:0] STEP_FF0 = 3'd0;
	localparam logic [STEP_W-1:0] STEP_FF1 = 3'd1;
	localparam logic [STEP_W-1:0] STEP_FF2 = 3'd2;
	localparam logic [STEP_W-1:0] STEP_FB1 = 3'd3;
	localparam logic [STEP_W-1:0] STEP_FB2 = 3'd4;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MAC   = 6'b000010,
		ST_ACC   = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_GAIN  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

endpackage

// ===== hw/rtl/biquad_df1_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_df1_filter
// direct-form-I biquad with per-channel history held in a small memory
// ----------------------------------------------------------------------------
//
// channel  group                   fields (lsb first)
// input    s_axis_t*               tdata: sample_in   tuser: chan
// output   m_axis_t*               tdata: sample_out  tuser: chan_out
// config   cfg_wr_en/index/data    ff_coef0..2, fb_coef1..2, out_gain
//
// each item runs from transfer to the next free slot in steps: five products
// through one shared multiplier, accumulate, round, gain product, output
// the history word of a channel is read at the transfer and written back
// once y is known, before the next item can be taken
// reset clears the per-channel valid bits; no clearing pass is run
// a result waiting on m_axis_tready holds the block in its last step only

module biquad_df1_filter #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample_in
	input  logic                                   s_axis_tuser,  // chan
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,  // sample_out
	output logic                                   m_axis_tuser,  // chan_out
	input  logic                                   cfg_wr_en,
	input  logic [bqd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [bqd_pkg::COEF_W-1:0]             cfg_data
);

	localparam int SB      = SAMPLE_BITS;
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MUL_A_W = bqd_pkg::COEF_W + 1;
	localparam int PROD_W  = MUL_A_W + SB;
	localparam int ACC_W   = SB + 26;
	localparam int WIDE_W  = SB + 5;
	localparam int HIST_W  = 4 * SB;

	localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (bqd_pkg::COEF_FRAC - 1);
	localparam logic signed [PROD_W-1:0] G_HALF   = PROD_W'(1) << (bqd_pkg::GAIN_FRAC - 1);
	localparam logic signed [SB-1:0]     S_MAX    = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0]     S_MIN    = {1'b1, {(SB-1){1'b0}}};

	function automatic logic [SB-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
		logic [SB-1:0] r;
		if (v > WIDE_W'(S_MAX))
			r = S_MAX;
		else if (v < WIDE_W'(S_MIN))
			r = S_MIN;
		else
			r = v[SB-1:0];
		return r;
	endfunction

	// configuration registers
	logic signed [bqd_pkg::COEF_W-1:0] ff_coef0_q, ff_coef1_q, ff_coef2_q;
	logic signed [bqd_pkg::COEF_W-1:0] fb_coef1_q, fb_coef2_q;
	logic        [bqd_pkg::GAIN_W-1:0] out_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_coef0_q <= '0;
			ff_coef1_q <= '0;
			ff_coef2_q <= '0;
			fb_coef1_q <= '0;
			fb_coef2_q <= '0;
			out_gain_q <= bqd_pkg::GAIN_UNITY;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bqd_pkg::REG_FF_COEF0: ff_coef0_q <= cfg_data;
				bqd_pkg::REG_FF_COEF1: ff_coef1_q <= cfg_data;
				bqd_pkg::REG_FF_COEF2: ff_coef2_q <= cfg_data;
				bqd_pkg::REG_FB_COEF1: fb_coef1_q <= cfg_data;
				bqd_pkg::REG_FB_COEF2: fb_coef2_q <= cfg_data;
				bqd_pkg::REG_OUT_GAIN: out_gain_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// control
	bqd_pkg::state_t             state_q;
	logic [bqd_pkg::STEP_W-1:0]  step_q;
	logic                        in_xfer;
	logic                        out_load;
	logic [IDX_W-1:0]            idx_in;

	assign s_axis_tready = (state_q == bqd_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == bqd_pkg::ST_OUT) && (!m_axis_tvalid || m_axis_tready);
	assign idx_in        = (CHANNELS == 1) ? '0 : IDX_W'(s_axis_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bqd_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				bqd_pkg::ST_IDLE: begin
					if (in_xfer) begin
						state_q <= bqd_pkg::ST_MAC;
						step_q  <= bqd_pkg::STEP_FF0;
					end
				end
				bqd_pkg::ST_MAC: begin
					if (step_q == bqd_pkg::STEP_FB2)
						state_q <= bqd_pkg::ST_ACC;
					else
						step_q <= step_q + 1'b1;
				end
				bqd_pkg::ST_ACC:   state_q <= bqd_pkg::ST_ROUND;
				bqd_pkg::ST_ROUND: state_q <= bqd_pkg::ST_GAIN;
				bqd_pkg::ST_GAIN:  state_q <= bqd_pkg::ST_OUT;
				bqd_pkg::ST_OUT: begin
					if (out_load)
						state_q <= bqd_pkg::ST_IDLE;
				end
				default: state_q <= bqd_pkg::ST_IDLE;
			endcase
		end
	end

	// item registers
	logic signed [SB-1:0] x_q;
	logic                 chan_q;
	logic [IDX_W-1:0]     idx_q;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q    <= s_axis_tdata[SB-1:0];
			chan_q <= s_axis_tuser;
			idx_q  <= idx_in;
		end
	end

	// history memory: {y2, y1, x2, x1} per channel
	logic [HIST_W-1:0]   hist_mem [CHANNELS];
	logic [HIST_W-1:0]   hist_rd_q;
	logic                hist_rd_vld_q;
	logic [CHANNELS-1:0] hist_vld_q;
	logic [HIST_W-1:0]   hist_word;
	logic signed [SB-1:0] hx1, hx2, hy1, hy2;
	logic signed [SB-1:0] y_sat;
	logic signed [SB-1:0] y_sat_q;

	assign hist_word = hist_rd_vld_q ? hist_rd_q : '0;
	assign hx1       = hist_word[SB-1:0];
	assign hx2       = hist_word[2*SB-1:SB];
	assign hy1       = hist_word[3*SB-1:2*SB];
	assign hy2       = hist_word[4*SB-1:3*SB];

	always_ff @(posedge clk) begin
		if (state_q == bqd_pkg::ST_ROUND)
			hist_mem[idx_q] <= {hy1, y_sat, hx1, x_q};
		if (in_xfer)
			hist_rd_q <= hist_mem[idx_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q    <= '0;
			hist_rd_vld_q <= 1'b0;
		end else begin
			if (state_q == bqd_pkg::ST_ROUND)
				hist_vld_q[idx_q] <= 1'b1;
			if (in_xfer)
				hist_rd_vld_q <= hist_vld_q[idx_in];
		end
	end

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [SB-1:0]      mul_b;
	logic                      mul_sub;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      sub_s1;

	always_comb begin
		mul_a   = {ff_coef0_q[bqd_pkg::COEF_W-1], ff_coef0_q};
		mul_b   = x_q;
		mul_sub = 1'b0;
		// gain product held while the result waits
		if ((state_q == bqd_pkg::ST_GAIN) || (state_q == bqd_pkg::ST_OUT)) begin
			mul_a = {1'b0, out_gain_q};
			mul_b = y_sat_q;
		end else begin
			case (step_q)
				bqd_pkg::STEP_FF0: begin
					mul_a = {ff_coef0_q[bqd_pkg::COEF_W-1], ff_coef0_q};
					mul_b = x_q;
				end
				bqd_pkg::STEP_FF1: begin
					mul_a = {ff_coef1_q[bqd_pkg::COEF_W-1], ff_coef1_q};
					mul_b = hx1;
				end
				bqd_pkg::STEP_FF2: begin
					mul_a = {ff_coef2_q[bqd_pkg::COEF_W-1], ff_coef2_q};
					mul_b = hx2;
				end
				bqd_pkg::STEP_FB1: begin
					mul_a   = {fb_coef1_q[bqd_pkg::COEF_W-1], fb_coef1_q};
					mul_b   = hy1;
					mul_sub = 1'b1;
				end
				bqd_pkg::STEP_FB2: begin
					mul_a   = {fb_coef2_q[bqd_pkg::COEF_W-1], fb_coef2_q};
					mul_b   = hy2;
					mul_sub = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		sub_s1  <= mul_sub;
	end

	// accumulate, round and saturate
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [WIDE_W-1:0] y_wide;
	logic                     acc_en;

	assign acc_en  = ((state_q == bqd_pkg::ST_MAC) && (step_q != bqd_pkg::STEP_FF0))
		|| (state_q == bqd_pkg::ST_ACC);
	assign acc_rnd = acc_q + ACC_HALF;
	assign y_wide  = acc_rnd[ACC_W-1:bqd_pkg::COEF_FRAC];
	assign y_sat   = sat_sample(y_wide);

	always_ff @(posedge clk) begin
		if (in_xfer)
			acc_q <= '0;
		else if (acc_en)
			acc_q <= sub_s1 ? acc_q - ACC_W'(prod_s1) : acc_q + ACC_W'(prod_s1);
		if (state_q == bqd_pkg::ST_ROUND)
			y_sat_q <= y_sat;
	end

	// gain rounding and output register
	logic signed [PROD_W-1:0] g_rnd;
	logic signed [WIDE_W-1:0] g_wide;
	logic [SB-1:0]            out_data_q;
	logic                     out_chan_q;
	logic                     out_vld_q;

	assign g_rnd  = prod_s1 + G_HALF;
	assign g_wide = g_rnd[PROD_W-1:bqd_pkg::GAIN_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= sat_sample(g_wide);
			out_chan_q <= chan_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);
	assign m_axis_tuser  = out_chan_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_xfer_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == bqd_pkg::ST_MAC) && (step_q == bqd_pkg::STEP_FF0))
		else $error("input transfer did not start the product sequence");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bqd_pkg::ST_MAC) |-> (step_q <= bqd_pkg::STEP_FB2))
		else $error("product step out of range");

	a_hist_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bqd_pkg::ST_ROUND) |=> hist_vld_q[idx_q])
		else $error("history entry not marked valid after write-back");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid && (m_axis_tuser == $past(chan_q)))
		else $error("result not presented with its channel");
`endif

endmodule
